// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the tag varint field parser.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion sampled on clk, disabled while rst_n is low
`define TVFP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tvfp assertion failed");

// assertion sampled on clk, active during reset as well
`define TVFP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tvfp assertion failed");

`endif

// ===== rtl/tvfp_pkg.sv =====
// ----------------------------------------------------------------------------
// tvfp_pkg
// Types and constants shared by the tag varint field parser modules.
// ----------------------------------------------------------------------------
package tvfp_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [3:0] VARINT_GROUPS = 4'd5;
  localparam logic [2:0] FIXED_LAST    = 3'd7;

  localparam logic [2:0] WIRE_VARINT  = 3'd0;
  localparam logic [2:0] WIRE_FIXED64 = 3'd1;
  localparam logic [2:0] WIRE_LEN     = 3'd2;

  localparam logic [1:0] EV_VARINT   = 2'd0;
  localparam logic [1:0] EV_FIXED64  = 2'd1;
  localparam logic [1:0] EV_STR_LEN  = 2'd2;
  localparam logic [1:0] EV_STR_BYTE = 2'd3;

  typedef enum logic [2:0] {
    PH_KEY,
    PH_VARINT,
    PH_FIXED,
    PH_LEN,
    PH_PAYLOAD
  } phase_t;

  typedef enum logic [2:0] {
    OP_CLEAR,
    OP_VARINT,
    OP_FIXED,
    OP_LEN,
    OP_PAYLOAD
  } op_t;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [4:0]  field_number;
    logic [63:0] field_value;
    logic        field_end;
  } out_item_t;

  // command from front end to back end
  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic [2:0] idx;
    logic       acc_en;
    logic       emit;
    logic       fld_end;
    logic [4:0] field;
  } cmd_t;

endpackage

// ===== rtl/tvfp_front.sv =====
// ----------------------------------------------------------------------------
// tvfp_front
// Accepts bytes, tracks the wire-format phase and issues commands.
// ----------------------------------------------------------------------------
module tvfp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  tvfp_pkg::in_item_t in_item,
  output logic              push,
  output tvfp_pkg::cmd_t    cmd
);
  import tvfp_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [4:0] field_r, field_nxt;
  logic [3:0] count_r, count_nxt;
  logic [7:0] rem_r, rem_nxt;
  logic [7:0] b;
  logic [2:0] wt;

  assign b  = in_item.byte_in;
  assign wt = b[2:0];

  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      unique case (phase_r)
        PH_KEY: begin
          unique case (wt)
            WIRE_VARINT:  phase_nxt = PH_VARINT;
            WIRE_FIXED64: phase_nxt = PH_FIXED;
            WIRE_LEN:     phase_nxt = PH_LEN;
            default:      phase_nxt = PH_KEY;
          endcase
        end
        PH_VARINT: if (!b[7]) phase_nxt = PH_KEY;
        PH_FIXED: if (count_r[2:0] == FIXED_LAST) phase_nxt = PH_KEY;
        PH_LEN: phase_nxt = (b == 8'd0) ? PH_KEY : PH_PAYLOAD;
        PH_PAYLOAD: if (rem_r == 8'd1) phase_nxt = PH_KEY;
        default: phase_nxt = PH_KEY;
      endcase
      if (in_item.last_byte) phase_nxt = PH_KEY;
    end
  end

  always_comb begin
    push        = 1'b0;
    cmd.op      = OP_CLEAR;
    cmd.data    = b;
    cmd.idx     = count_r[2:0];
    cmd.acc_en  = 1'b0;
    cmd.emit    = 1'b0;
    cmd.fld_end = 1'b0;
    cmd.field   = field_r;
    field_nxt   = field_r;
    count_nxt   = count_r;
    rem_nxt     = rem_r;
    if (accept) begin
      unique case (phase_r)
        PH_VARINT: begin
          push        = 1'b1;
          cmd.op      = OP_VARINT;
          cmd.acc_en  = (count_r < VARINT_GROUPS);
          cmd.emit    = !b[7];
          cmd.fld_end = 1'b1;
          if (count_r < VARINT_GROUPS) count_nxt = count_r + 4'd1;
        end
        PH_FIXED: begin
          push        = 1'b1;
          cmd.op      = OP_FIXED;
          cmd.emit    = (count_r[2:0] == FIXED_LAST);
          cmd.fld_end = 1'b1;
          count_nxt   = count_r + 4'd1;
        end
        PH_LEN: begin
          push        = 1'b1;
          cmd.op      = OP_LEN;
          cmd.emit    = 1'b1;
          cmd.fld_end = (b == 8'd0);
          rem_nxt     = b;
        end
        PH_PAYLOAD: begin
          push        = 1'b1;
          cmd.op      = OP_PAYLOAD;
          cmd.emit    = 1'b1;
          cmd.fld_end = (rem_r == 8'd1);
          rem_nxt     = rem_r - 8'd1;
        end
        default: begin
          if (wt < 3'd3) begin
            push      = 1'b1;
            cmd.op    = OP_CLEAR;
            field_nxt = b[7:3];
            count_nxt = 4'd0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_KEY;
      field_r <= '0;
      count_r <= '0;
      rem_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      field_r <= field_nxt;
      count_r <= count_nxt;
      rem_r   <= rem_nxt;
    end
  end

endmodule

// ===== rtl/tvfp_queue.sv =====
// ----------------------------------------------------------------------------
// tvfp_queue
// Small command FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module tvfp_queue #(
  parameter int DEPTH = tvfp_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tvfp_pkg::cmd_t push_cmd,
  input  logic           pop,
  output logic           full,
  output logic           q_valid,
  output tvfp_pkg::cmd_t q_cmd
);
  import tvfp_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign q_valid = (count_r != '0);
  assign q_cmd   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_cmd;
  end

endmodule

// ===== rtl/tvfp_back.sv =====
// ----------------------------------------------------------------------------
// tvfp_back
// Executes commands: accumulates values and drives the result register.
// ----------------------------------------------------------------------------
module tvfp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  tvfp_pkg::cmd_t     q_cmd,
  output logic               pop,
  input  logic               out_stall,
  output logic               out_valid,
  output tvfp_pkg::out_item_t out_data
);
  import tvfp_pkg::*;

  logic [63:0] acc_r, acc_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_r, out_nxt;
  logic [6:0]  grp;
  logic [31:0] vsh;
  logic [63:0] fsh;

  assign grp = q_cmd.data[6:0];
  assign fsh = {56'd0, q_cmd.data} << {q_cmd.idx, 3'b000};

  always_comb begin
    unique case (q_cmd.idx)
      3'd0:    vsh = {25'd0, grp};
      3'd1:    vsh = {18'd0, grp, 7'd0};
      3'd2:    vsh = {11'd0, grp, 14'd0};
      3'd3:    vsh = {4'd0, grp, 21'd0};
      3'd4:    vsh = {grp[3:0], 28'd0};
      default: vsh = '0;
    endcase
  end

  assign pop = q_valid && (!q_cmd.emit || !out_valid_r || !out_stall);

  always_comb begin
    acc_nxt = acc_r;
    if (pop) begin
      unique case (q_cmd.op)
        OP_CLEAR:  acc_nxt = '0;
        OP_VARINT: if (q_cmd.acc_en) acc_nxt = acc_r | {32'd0, vsh};
        OP_FIXED:  acc_nxt = acc_r | fsh;
        default:   acc_nxt = acc_r;
      endcase
    end
  end

  always_comb begin
    out_nxt.field_number = q_cmd.field;
    out_nxt.field_end    = q_cmd.fld_end;
    unique case (q_cmd.op)
      OP_VARINT: begin
        out_nxt.event_kind  = EV_VARINT;
        out_nxt.field_value = {32'd0, acc_nxt[31:0]};
      end
      OP_FIXED: begin
        out_nxt.event_kind  = EV_FIXED64;
        out_nxt.field_value = acc_nxt;
      end
      OP_LEN: begin
        out_nxt.event_kind  = EV_STR_LEN;
        out_nxt.field_value = {56'd0, q_cmd.data};
      end
      default: begin
        out_nxt.event_kind  = EV_STR_BYTE;
        out_nxt.field_value = {56'd0, q_cmd.data};
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop && q_cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_cmd.emit) out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/tag_varint_field_parser.sv =====
// ----------------------------------------------------------------------------
// tag_varint_field_parser
// Tag-length-value wire-format byte parser: varint, fixed64 and string fields.
// ----------------------------------------------------------------------------
// Takes one byte per clock with no bubbles while the result side keeps up.
// Result-bearing bytes are queued as commands and registered onto out_data when
// popped. The front end keeps the parse phase, the back end keeps the
// accumulator and the result register, and a QUEUE_DEPTH-entry command FIFO
// between them sets how long in_stall stays low while out_stall is held.
// ----------------------------------------------------------------------------
module tag_varint_field_parser #(
  parameter int QUEUE_DEPTH = tvfp_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tvfp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output tvfp_pkg::out_item_t out_data
);
  import tvfp_pkg::*;

  logic accept;
  logic push;
  logic pop;
  logic full;
  logic q_valid;
  cmd_t push_cmd;
  cmd_t q_cmd;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  tvfp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_item (in_data),
    .push    (push),
    .cmd     (push_cmd)
  );

  tvfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (full),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  tvfp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/tvfp_checker.sv =====
// ----------------------------------------------------------------------------
// tvfp_checker
// Port-level checks for the tag varint field parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tvfp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input tvfp_pkg::out_item_t out_data
);
  import tvfp_pkg::*;

  logic is_varint;
  logic is_whole;
  logic hi_zero;

  assign is_varint = (out_data.event_kind == EV_VARINT);
  assign is_whole  = is_varint || (out_data.event_kind == EV_FIXED64);
  assign hi_zero   = (out_data.field_value[63:32] == 32'd0);

  `TVFP_ASSERT(a_out_hold, clk, rst_n, (out_valid && out_stall) |=> out_valid)
  `TVFP_ASSERT(a_out_stable, clk, rst_n, (out_valid && out_stall) |=> $stable(out_data))
  `TVFP_ASSERT_ALWAYS(a_rst_idle, clk, !rst_n |=> !out_valid)
  `TVFP_ASSERT(a_varint_32, clk, rst_n, (out_valid && is_varint) |-> hi_zero)
  `TVFP_ASSERT(a_fixed_end, clk, rst_n, (out_valid && is_whole) |-> out_data.field_end)

endmodule

bind tag_varint_field_parser tvfp_checker u_tvfp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== tb/tag_varint_field_parser_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tag_varint_field_parser_test
// Self-checking bench for the tag-length-value byte parser. A short table of
// directed bytes covers the field extremes and the corner cases. Random
// messages follow, built from well-formed fields with some noise and cut
// buffers. Every accepted byte runs through a behavioral parser model, and
// each result transaction is checked against the oldest prediction. The
// sender idles and the receiver stalls at several rates, and one long
// receiver hold-off fills the block until it stalls its input.
// ----------------------------------------------------------------------------
module tag_varint_field_parser_test;
  import tvfp_pkg::*;

  localparam int IDLE_LIMIT = 1000;
  localparam int HOLD_CYCLES = 150;
  localparam int DRAIN_CYCLES = 8;

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_QUIET,
    ROW_RESULT
  } row_kind_t;

  typedef struct packed {
    in_item_t  item;
    row_kind_t kind;
    out_item_t want;
  } stim_row_t;

  localparam out_item_t NO_RESULT = '0;
  localparam int NUM_DIRECTED = 25;
  localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
    '{'{8'h07, 1'b1}, ROW_QUIET, NO_RESULT},
    '{'{8'hFB, 1'b0}, ROW_QUIET, NO_RESULT},
    '{'{8'hF8, 1'b0}, ROW_QUIET, NO_RESULT},
    '{'{8'hFF, 1'b0}, ROW_QUIET, NO_RESULT},
    '{'{8'hFF, 1'b0}, ROW_QUIET, NO_RESULT},
    '{'{8'hFF, 1'b0}, ROW_QUIET, NO_RESULT},
    '{'{8'hFF, 1'b0}, ROW_QUIET, NO_RESULT},
    '{'{8'hFF, 1'b0}, ROW_QUIET, NO_RESULT},
    '{'{8'h7F, 1'b0}, ROW_RESULT, '{EV_VARINT, 5'd31, 64'hFFFF_FFFF, 1'b1}},
    '{'{8'h00, 1'b0}, ROW_QUIET, NO_RESULT},
    '{'{8'h00, 1'b0}, ROW_RESULT, '{EV_VARINT, 5'd0, 64'd0, 1'b1}},
    '{'{8'h09, 1'b0}, ROW_QUIET, NO_RESULT},
    '{'{8'hFF, 1'b0}, ROW_QUIET, NO_RESULT},
    '{'{8'hFF, 1'b0}, ROW_QUIET, NO_RESULT},
    '{'{8'hFF, 1'b0}, ROW_QUIET, NO_RESULT},
    '{'{8'hFF, 1'b0}, ROW_QUIET, NO_RESULT},
    '{'{8'hFF, 1'b0}, ROW_QUIET, NO_RESULT},
    '{'{8'hFF, 1'b0}, ROW_QUIET, NO_RESULT},
    '{'{8'hFF, 1'b0}, ROW_QUIET, NO_RESULT},
    '{'{8'hFF, 1'b0}, ROW_RESULT, '{EV_FIXED64, 5'd1, {64{1'b1}}, 1'b1}},
    '{'{8'h12, 1'b0}, ROW_QUIET, NO_RESULT},
    '{'{8'h00, 1'b0}, ROW_RESULT, '{EV_STR_LEN, 5'd2, 64'd0, 1'b1}},
    '{'{8'h1A, 1'b0}, ROW_QUIET, NO_RESULT},
    '{'{8'h03, 1'b0}, ROW_PREDICT, NO_RESULT},
    '{'{8'h80, 1'b1}, ROW_PREDICT, NO_RESULT}
  };

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  stim_row_t byte_q[$];
  out_item_t event_q[$];

  // parser model state
  phase_t      phase;
  logic [4:0]  cur_field;
  logic [63:0] acc;
  logic [3:0]  grp_count;
  logic [7:0]  remaining;

  int idle_pct;
  int stall_pct;
  int hold_req;
  int hold_left;
  int errors;
  int bytes_pushed;
  int bytes_taken;
  int in_stalled_cycles;
  int idle_cycles;
  int events_seen [4];

  stim_row_t taken_row;
  bit        has_event;
  out_item_t model_event;
  out_item_t want_event;

  tag_varint_field_parser uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void parse_byte(input in_item_t it, output bit got,
                                     output out_item_t ev);
    logic [7:0] b;
    b = it.byte_in;
    got = 1'b0;
    ev = '0;
    ev.field_number = cur_field;
    case (phase)
      PH_VARINT: begin
        if (grp_count < VARINT_GROUPS) begin
          acc = acc | (({57'd0, b[6:0]} << (7 * grp_count)) & 64'hFFFF_FFFF);
          grp_count = grp_count + 4'd1;
        end
        if (!b[7]) begin
          got = 1'b1;
          ev.event_kind = EV_VARINT;
          ev.field_value = acc & 64'hFFFF_FFFF;
          ev.field_end = 1'b1;
          phase = PH_KEY;
        end
      end
      PH_FIXED: begin
        acc = acc | ({56'd0, b} << (8 * grp_count[2:0]));
        if (grp_count[2:0] == FIXED_LAST) begin
          got = 1'b1;
          ev.event_kind = EV_FIXED64;
          ev.field_value = acc;
          ev.field_end = 1'b1;
          phase = PH_KEY;
        end
        grp_count = grp_count + 4'd1;
      end
      PH_LEN: begin
        got = 1'b1;
        ev.event_kind = EV_STR_LEN;
        ev.field_value = {56'd0, b};
        ev.field_end = (b == 8'd0);
        remaining = b;
        phase = (b == 8'd0) ? PH_KEY : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        remaining = remaining - 8'd1;
        got = 1'b1;
        ev.event_kind = EV_STR_BYTE;
        ev.field_value = {56'd0, b};
        ev.field_end = (remaining == 8'd0);
        if (remaining == 8'd0) phase = PH_KEY;
      end
      default: begin
        phase = PH_KEY;
        if (b[2:0] == WIRE_VARINT || b[2:0] == WIRE_FIXED64 || b[2:0] == WIRE_LEN) begin
          cur_field = b[7:3];
          acc = '0;
          grp_count = '0;
          case (b[2:0])
            WIRE_VARINT:  phase = PH_VARINT;
            WIRE_FIXED64: phase = PH_FIXED;
            default:      phase = PH_LEN;
          endcase
        end
      end
    endcase
    if (it.last_byte) phase = PH_KEY;
  endfunction

  // sender: offers queued bytes, runs the model on each accepted transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        taken_row = byte_q.pop_front();
        bytes_taken++;
        parse_byte(taken_row.item, has_event, model_event);
        case (taken_row.kind)
          ROW_PREDICT: if (has_event) event_q.push_back(model_event);
          ROW_RESULT:  event_q.push_back(taken_row.want);
          default: ;
        endcase
      end
      if (in_valid && in_stall) begin
        in_stalled_cycles++;
      end else if (byte_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        in_valid <= 1'b1;
        in_data <= byte_q[0].item;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (event_q.size() == 0) begin
        $error("unexpected result transaction: %p", out_data);
        errors++;
      end else begin
        want_event = event_q.pop_front();
        events_seen[out_data.event_kind]++;
        if (out_data.event_kind !== want_event.event_kind) begin
          $error("event_kind expected %0d got %0d", want_event.event_kind,
                 out_data.event_kind);
          errors++;
        end
        if (out_data.field_number !== want_event.field_number) begin
          $error("field_number expected %0d got %0d", want_event.field_number,
                 out_data.field_number);
          errors++;
        end
        if (out_data.field_value !== want_event.field_value) begin
          $error("field_value expected %h got %h", want_event.field_value,
                 out_data.field_value);
          errors++;
        end
        if (out_data.field_end !== want_event.field_end) begin
          $error("field_end expected %0b got %0b", want_event.field_end,
                 out_data.field_end);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("tag_varint_field_parser_test: FAIL");
        $finish;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic last);
    stim_row_t r;
    r.item.byte_in = b;
    r.item.last_byte = last;
    r.kind = ROW_PREDICT;
    r.want = NO_RESULT;
    byte_q.push_back(r);
    bytes_pushed++;
  endtask

  function automatic logic pick_last(input bit final_byte);
    return final_byte ? ($urandom_range(7) == 0) : ($urandom_range(39) == 0);
  endfunction

  task automatic push_string(input logic [4:0] fld, input int len);
    push_byte({fld, WIRE_LEN}, pick_last(1'b0));
    push_byte(len[7:0], pick_last(len == 0));
    for (int i = 0; i < len; i++) begin
      push_byte(8'($urandom_range(255)), pick_last(i == len - 1));
    end
  endtask

  task automatic push_field();
    int pick;
    int n;
    logic [4:0] fld;
    logic [7:0] b;
    pick = $urandom_range(99);
    fld = 5'($urandom_range(31));
    if (pick < 30) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(6, 9) : $urandom_range(1, 5);
      push_byte({fld, WIRE_VARINT}, pick_last(1'b0));
      for (int i = 0; i < n; i++) begin
        b = 8'($urandom_range(255));
        b[7] = (i != n - 1);
        push_byte(b, pick_last(i == n - 1));
      end
    end else if (pick < 50) begin
      push_byte({fld, WIRE_FIXED64}, pick_last(1'b0));
      for (int i = 0; i < 8; i++) push_byte(8'($urandom_range(255)), pick_last(i == 7));
    end else if (pick < 80) begin
      push_string(fld, ($urandom_range(3) == 0) ? $urandom_range(9, 40) : $urandom_range(8));
    end else if (pick < 88) begin
      push_byte({fld, 3'($urandom_range(3, 7))}, pick_last(1'b1));
    end else begin
      push_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
    end
  endtask

  task automatic wait_drained();
    while (byte_q.size() != 0 || event_q.size() != 0) @(negedge clk);
  endtask

  task automatic run_phase(input int idle, input int stall, input int target);
    int start;
    @(negedge clk);
    idle_pct = idle;
    stall_pct = stall;
    start = bytes_pushed;
    while (bytes_pushed - start < target) push_field();
    wait_drained();
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    out_stall <= 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 0;
    hold_left = 0;
    errors = 0;
    bytes_pushed = 0;
    bytes_taken = 0;
    in_stalled_cycles = 0;
    idle_cycles = 0;
    events_seen = '{default: 0};
    phase = PH_KEY;
    cur_field = '0;
    acc = '0;
    grp_count = '0;
    remaining = '0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      byte_q.push_back(DIRECTED[i]);
      bytes_pushed++;
    end
    wait_drained();

    // longest string the length byte allows, at full rate
    @(negedge clk);
    push_string(5'd31, 255);
    wait_drained();

    run_phase(0, 0, 25);
    run_phase(67, 0, 25);
    run_phase(0, 67, 25);
    run_phase(27, 27, 25);

    // receiver holds off while the sender keeps going
    @(negedge clk);
    idle_pct = 0;
    stall_pct = 0;
    hold_req = HOLD_CYCLES;
    while (bytes_pushed < bytes_taken + 40) push_field();
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d bytes; results: %0d varint, %0d fixed64, %0d length, %0d payload",
             bytes_taken, events_seen[EV_VARINT], events_seen[EV_FIXED64],
             events_seen[EV_STR_LEN], events_seen[EV_STR_BYTE]);
    $display("input stalled for %0d cycles, including a %0d-cycle output hold-off",
             in_stalled_cycles, HOLD_CYCLES);
    if (errors == 0) begin
      $display("tag_varint_field_parser_test: PASS");
    end else begin
      $display("tag_varint_field_parser_test: FAIL");
    end
    $finish;
  end

endmodule
